[design/vcrb_pkg.sv]
package vcrb_pkg;

   localparam int unsigned QUEUES_DEFAULT = 2;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned MODE_W   = 2;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned REQ_USER_W = 8;
   localparam int unsigned RSP_DATA_W = 40;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_KBD   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // register offsets
   localparam logic [OFFSET_W-1:0] OFF_MAGIC       = 12'h000;
   localparam logic [OFFSET_W-1:0] OFF_VERSION     = 12'h004;
   localparam logic [OFFSET_W-1:0] OFF_DEVICE_ID   = 12'h008;
   localparam logic [OFFSET_W-1:0] OFF_VENDOR_ID   = 12'h00c;
   localparam logic [OFFSET_W-1:0] OFF_FEATURES    = 12'h010;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_SEL   = 12'h030;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_MAX   = 12'h034;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_NUM   = 12'h038;
   localparam logic [OFFSET_W-1:0] OFF_QUEUE_READY = 12'h044;
   localparam logic [OFFSET_W-1:0] OFF_NOTIFY      = 12'h050;
   localparam logic [OFFSET_W-1:0] OFF_INT_STATUS  = 12'h060;
   localparam logic [OFFSET_W-1:0] OFF_INT_ACK     = 12'h064;
   localparam logic [OFFSET_W-1:0] OFF_STATUS      = 12'h070;
   localparam logic [OFFSET_W-1:0] OFF_DESC_BASE   = 12'h080;
   localparam logic [OFFSET_W-1:0] OFF_AVAIL_BASE  = 12'h090;
   localparam logic [OFFSET_W-1:0] OFF_USED_BASE   = 12'h0a0;
   localparam logic [OFFSET_W-1:0] OFF_CONFIG_GEN  = 12'h0fc;

   // identity words
   localparam logic [WORD_W-1:0] ID_MAGIC      = 32'h7472_6976;
   localparam logic [WORD_W-1:0] ID_VERSION    = 32'd2;
   localparam logic [WORD_W-1:0] ID_DEVICE     = 32'd3;
   localparam logic [WORD_W-1:0] ID_VENDOR     = 32'h0000_ffff;
   localparam logic [WORD_W-1:0] ID_FEATURES   = 32'd1;
   localparam logic [WORD_W-1:0] ID_CONFIG_GEN = 32'd0;

   typedef struct packed {
      logic              notify_error;
      logic              notify_fire;
      logic              irq_release;
      logic [WORD_W-1:0] read_data;
   } result_type;

endpackage

[design/vcrb_regs.sv]
module vcrb_regs #(
   parameter int unsigned QUEUES = vcrb_pkg::QUEUES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  vcrb_pkg::mode_type            mode,
   input  logic [vcrb_pkg::OFFSET_W-1:0] offset,
   input  logic [vcrb_pkg::WORD_W-1:0]   write_data,
   output vcrb_pkg::result_type          result
);
   import vcrb_pkg::*;

   localparam int unsigned SEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic [WORD_W-1:0] queue_select_ff, queue_select_in;
   logic [WORD_W-1:0] queue_count_ff, queue_count_in;
   logic [WORD_W-1:0] int_status_ff, int_status_in;
   logic [WORD_W-1:0] dev_status_ff, dev_status_in;
   logic [WORD_W-1:0] queue_ready_ff [QUEUES];
   logic [WORD_W-1:0] desc_base_ff [QUEUES];
   logic [WORD_W-1:0] avail_base_ff [QUEUES];
   logic [WORD_W-1:0] used_base_ff [QUEUES];

   logic             sel_ok;
   logic [SEL_W-1:0] sel_idx;
   logic             is_write;
   logic [WORD_W-1:0] acked_status;
   logic [WORD_W-1:0] read_word;

   assign sel_ok       = queue_select_ff < WORD_W'(QUEUES);
   assign sel_idx      = queue_select_ff[SEL_W-1:0];
   assign is_write     = accept && (mode == MODE_WRITE);
   assign acked_status = int_status_ff & ~write_data;

   always_comb begin
      unique case (offset)
         OFF_MAGIC:       read_word = ID_MAGIC;
         OFF_VERSION:     read_word = ID_VERSION;
         OFF_DEVICE_ID:   read_word = ID_DEVICE;
         OFF_VENDOR_ID:   read_word = ID_VENDOR;
         OFF_FEATURES:    read_word = ID_FEATURES;
         OFF_QUEUE_MAX:   read_word = WORD_W'(QUEUES);
         OFF_CONFIG_GEN:  read_word = ID_CONFIG_GEN;
         OFF_QUEUE_READY: read_word = sel_ok ? queue_ready_ff[sel_idx] : '0;
         OFF_INT_STATUS:  read_word = int_status_ff;
         OFF_STATUS:      read_word = dev_status_ff;
         default:         read_word = '0;
      endcase
   end

   always_comb begin
      result = '0;
      unique case (mode)
         MODE_READ: result.read_data = read_word;
         MODE_WRITE: begin
            if (offset == OFF_NOTIFY) begin
               result.notify_error = write_data > WORD_W'(1);
               result.notify_fire  = write_data == WORD_W'(1);
            end
            if (offset == OFF_INT_ACK) begin
               result.irq_release = acked_status == '0;
            end
         end
         MODE_KBD, MODE_NONE: result = '0;
         default: result = '0;
      endcase
   end

   always_comb begin
      queue_select_in = queue_select_ff;
      queue_count_in  = queue_count_ff;
      dev_status_in   = dev_status_ff;
      int_status_in   = int_status_ff;
      if (is_write) begin
         unique case (offset)
            OFF_QUEUE_SEL: queue_select_in = write_data;
            OFF_QUEUE_NUM: queue_count_in  = write_data;
            OFF_STATUS:    dev_status_in   = write_data;
            OFF_INT_ACK:   int_status_in   = acked_status;
            default: ;
         endcase
      end else if (accept && (mode == MODE_KBD)) begin
         int_status_in = int_status_ff | WORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_select_ff <= '0;
         queue_count_ff  <= '0;
         int_status_ff   <= '0;
         dev_status_ff   <= '0;
         for (int q = 0; q < QUEUES; q++) begin
            queue_ready_ff[q] <= '0;
            desc_base_ff[q]   <= '0;
            avail_base_ff[q]  <= '0;
            used_base_ff[q]   <= '0;
         end
      end else begin
         queue_select_ff <= queue_select_in;
         queue_count_ff  <= queue_count_in;
         int_status_ff   <= int_status_in;
         dev_status_ff   <= dev_status_in;
         // per-queue writes land only when the select is in range
         if (is_write && sel_ok) begin
            unique case (offset)
               OFF_QUEUE_READY: queue_ready_ff[sel_idx] <= write_data;
               OFF_DESC_BASE:   desc_base_ff[sel_idx]   <= write_data;
               OFF_AVAIL_BASE:  avail_base_ff[sel_idx]  <= write_data;
               OFF_USED_BASE:   used_base_ff[sel_idx]   <= write_data;
               default: ;
            endcase
         end
      end
   end

endmodule

[design/vcrb_out_buf.sv]
module vcrb_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vcrb_pkg::result_type push_data,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output vcrb_pkg::result_type out_data
);
   import vcrb_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign has_room  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/virtio_console_register_block_core.sv]
// Each accepted request beat pushes its result into a two-entry result buffer
// that holds results under stall. Throughput: one request beat per cycle while
// the buffer has room; register decode and update finish in the accept cycle.
// Reset: synchronous, active high; clears all registers and empties the buffer.
module virtio_console_register_block_core #(
   parameter int unsigned QUEUES = vcrb_pkg::QUEUES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [11:0] offset, [43:12] write_data, [47:44] zero
   input  logic [vcrb_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode, [7:2] zero
   input  logic [vcrb_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] read_data, [32] irq_release, [33] notify_fire, [34] notify_error,
   // [39:35] zero
   output logic [vcrb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vcrb_pkg::*;

   logic       req_beat;
   result_type result;
   result_type out_result;

   assign req_beat = req_tvalid && req_tready;

   vcrb_regs #(
      .QUEUES(QUEUES)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_beat),
      .mode       (mode_type'(req_tuser[MODE_W-1:0])),
      .offset     (req_tdata[OFFSET_W-1:0]),
      .write_data (req_tdata[OFFSET_W +: WORD_W]),
      .result     (result)
   );

   vcrb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_beat),
      .push_data (result),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(result_type))'(0), out_result};

`ifndef SYNTHESIS
   a_beat_yields_result: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_tvalid)
      else $error("accepted request left no pending result");

   a_full_means_valid: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("buffer reports full while empty");

   a_notify_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_result.notify_fire && out_result.notify_error))
      else $error("notify fire and error both set");
`endif

endmodule
